[src/tba_pkg.sv]
// ----------------------------------------------------------------------------
// tba_pkg
// Shared widths, constants and payload types of the trade bar aggregator.
// ----------------------------------------------------------------------------
package tba_pkg;

    localparam int unsigned TIME_W   = 44;
    localparam int unsigned PRICE_W  = 32;
    localparam int unsigned QTY_W    = 32;
    localparam int unsigned VOL_W    = 48;
    localparam int unsigned CNT_W    = 24;
    localparam int unsigned RUN_W    = 16;

    // Bucket length in milliseconds.
    localparam int unsigned BUCKET_MS = 1000;

    // Gap bars emitted after one finished bar at most.
    localparam int unsigned MAX_GAP_BARS = 62;
    localparam int unsigned GAP_CNT_W    = $clog2(MAX_GAP_BARS + 2);

    // Queue between the front end and the bar builder.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Remainder unit: the timestamp is reduced modulo the bucket length one
    // byte per cycle.
    localparam int unsigned REM_W      = $clog2(BUCKET_MS);
    localparam int unsigned DIGIT_W    = 8;
    localparam int unsigned DIV_STEPS  = (TIME_W + DIGIT_W - 1) / DIGIT_W;
    localparam int unsigned DIV_W      = DIV_STEPS * DIGIT_W;
    localparam int unsigned STEP_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    typedef struct packed {
        logic [TIME_W-1:0]  trade_time_ms;
        logic [PRICE_W-1:0] trade_price;
        logic [QTY_W-1:0]   trade_qty;
        logic               seller_aggressor;
    } t_trade;

    // A valid trade after bucketing, as it travels through the queue.
    typedef struct packed {
        logic [TIME_W-1:0]  bucket;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic               sell;
    } t_work;

    typedef struct packed {
        logic [TIME_W-1:0]  bar_time_ms;
        logic [PRICE_W-1:0] open_price;
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] low_price;
        logic [PRICE_W-1:0] close_price;
        logic [VOL_W-1:0]   total_volume;
        logic [CNT_W-1:0]   total_trades;
        logic [VOL_W-1:0]   buy_side_volume;
        logic [CNT_W-1:0]   buy_trades;
        logic [RUN_W-1:0]   longest_run;
        logic               is_gap_bar;
        logic               last;
    } t_bar;

endpackage

[src/tba_front.sv]
// ----------------------------------------------------------------------------
// tba_front
// Accepts trades, drops invalid ones and works out the one-second bucket of
// each valid trade before handing it to the queue.
// ----------------------------------------------------------------------------
module tba_front import tba_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  t_trade i_in_data,
    output logic   o_push,
    input  logic   i_full,
    output t_work  o_work
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                r_state, n_state;
    logic [STEP_CNT_W-1:0]  r_step, n_step;
    logic [REM_W-1:0]       r_rem, n_rem;
    logic [DIV_W-1:0]       r_shift, n_shift;
    t_trade                 r_item, n_item;
    logic                   w_accept;
    logic                   w_valid_trade;

    // Feeds one byte of the dividend into the remainder, most significant
    // bit first. The remainder stays below the bucket length throughout.
    function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0]   rem,
                                                  input logic [DIGIT_W-1:0] digit);
        logic [REM_W:0] acc;
        acc = {1'b0, rem};
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            acc = {acc[REM_W-1:0], digit[i]};
            if (acc >= (REM_W+1)'(BUCKET_MS)) begin
                acc = acc - (REM_W+1)'(BUCKET_MS);
            end
        end
        return acc[REM_W-1:0];
    endfunction

    assign o_in_stall    = (r_state != F_IDLE);
    assign w_accept      = i_in_valid && !o_in_stall;
    assign w_valid_trade = (i_in_data.trade_time_ms != '0) &&
                           (i_in_data.trade_price != '0) &&
                           (i_in_data.trade_qty != '0);

    assign o_push        = (r_state == F_PUSH) && !i_full;
    assign o_work.bucket = r_item.trade_time_ms - TIME_W'(r_rem);
    assign o_work.price  = r_item.trade_price;
    assign o_work.qty    = r_item.trade_qty;
    assign o_work.sell   = r_item.seller_aggressor;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_rem   = r_rem;
        n_shift = r_shift;
        n_item  = r_item;
        case (r_state)
            F_IDLE: begin
                // An invalid trade is taken and forgotten in the same transfer.
                if (w_accept && w_valid_trade) begin
                    n_item  = i_in_data;
                    n_shift = DIV_W'(i_in_data.trade_time_ms);
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                n_rem   = rem_step(r_rem, r_shift[DIV_W-1 -: DIGIT_W]);
                n_shift = r_shift << DIGIT_W;
                n_step  = r_step + STEP_CNT_W'(1);
                if (r_step == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_rem   <= n_rem;
        r_shift <= n_shift;
        r_item  <= n_item;
    end

endmodule

[src/tba_fifo.sv]
// ----------------------------------------------------------------------------
// tba_fifo
// Short first-in first-out queue of bucketed trades between the front end
// and the bar builder.
// ----------------------------------------------------------------------------
module tba_fifo import tba_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_wdata,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_work o_rdata
);

    t_work                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]  r_count, n_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                : r_wr_ptr + QUEUE_AW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                : r_rd_ptr + QUEUE_AW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + QUEUE_CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

[src/tba_back.sv]
// ----------------------------------------------------------------------------
// tba_back
// Bar builder: folds bucketed trades into the bar in progress, emits the
// finished bar and any gap bars, and tracks same-side runs.
// ----------------------------------------------------------------------------
module tba_back import tba_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_run_track_en,
    input  logic  i_q_valid,
    output logic  o_q_pop,
    input  t_work i_q_data,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_bar  o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BAR  = 3'b010,
        S_GAP  = 3'b100
    } t_bstate;

    localparam logic [1:0] SIDE_NONE = 2'd0;
    localparam logic [1:0] SIDE_BUY  = 2'd1;
    localparam logic [1:0] SIDE_SELL = 2'd2;

    t_bstate               r_state, n_state;
    logic                  r_bar_open, n_bar_open;
    logic [1:0]            r_prev_side, n_prev_side;
    logic [RUN_W-1:0]      r_run_count, n_run_count;
    logic                  r_out_valid, n_out_valid;

    logic [TIME_W-1:0]     r_bucket_start, n_bucket_start;
    logic [PRICE_W-1:0]    r_open, n_open;
    logic [PRICE_W-1:0]    r_high, n_high;
    logic [PRICE_W-1:0]    r_low, n_low;
    logic [PRICE_W-1:0]    r_close, n_close;
    logic [VOL_W-1:0]      r_vol, n_vol;
    logic [CNT_W-1:0]      r_trades, n_trades;
    logic [VOL_W-1:0]      r_bvol, n_bvol;
    logic [CNT_W-1:0]      r_btrades, n_btrades;
    logic [RUN_W-1:0]      r_max_run, n_max_run;
    t_work                 r_item, n_item;
    logic [RUN_W-1:0]      r_run_len, n_run_len;
    logic [TIME_W:0]       r_gap_time, n_gap_time;
    logic [GAP_CNT_W-1:0]  r_gap_cnt, n_gap_cnt;
    t_bar                  r_out, n_out;

    logic                  w_can_load;
    logic                  w_pop;
    logic [1:0]            w_side;
    logic [1:0]            w_side_next;
    logic [RUN_W-1:0]      w_run_next;
    logic [RUN_W-1:0]      w_run_len;
    logic                  w_new_bucket;
    logic                  w_has_gap;
    logic [TIME_W:0]       w_gap_next;
    logic [GAP_CNT_W-1:0]  w_gap_cnt_inc;
    logic                  w_more_gaps;

    // Trade folding
    logic                  w_apply;
    t_work                 w_src;
    logic [RUN_W-1:0]      w_src_run;
    logic                  w_fresh;
    logic [PRICE_W-1:0]    w_base_high;
    logic [PRICE_W-1:0]    w_base_low;
    logic [VOL_W-1:0]      w_base_vol;
    logic [CNT_W-1:0]      w_base_trades;
    logic [VOL_W-1:0]      w_base_bvol;
    logic [CNT_W-1:0]      w_base_btrades;
    logic [RUN_W-1:0]      w_base_run;
    logic [VOL_W:0]        w_vol_sum;
    logic [VOL_W:0]        w_bvol_sum;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_can_load  = !r_out_valid || !i_out_stall;
    assign w_pop       = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop     = w_pop;

    // Run tracking happens as each trade leaves the queue, whatever the
    // bucket does.
    always_comb begin
        w_side      = i_q_data.sell ? SIDE_SELL : SIDE_BUY;
        w_side_next = r_prev_side;
        w_run_next  = r_run_count;
        w_run_len   = RUN_W'(1);
        if (i_run_track_en) begin
            if (w_side == r_prev_side) begin
                if (r_run_count != '1) begin
                    w_run_next = r_run_count + RUN_W'(1);
                end
            end else begin
                w_side_next = w_side;
                w_run_next  = RUN_W'(1);
            end
            w_run_len = w_run_next;
        end
    end

    assign w_new_bucket  = i_q_data.bucket != r_bucket_start;
    assign w_has_gap     = (r_gap_time < {1'b0, r_item.bucket}) && (MAX_GAP_BARS != 0);
    assign w_gap_next    = r_gap_time + (TIME_W+1)'(BUCKET_MS);
    assign w_gap_cnt_inc = r_gap_cnt + GAP_CNT_W'(1);
    assign w_more_gaps   = (w_gap_next < {1'b0, r_item.bucket}) &&
                           (w_gap_cnt_inc < GAP_CNT_W'(MAX_GAP_BARS));

    // Folds one trade into the bar, starting a fresh bar where asked.
    always_comb begin
        w_src     = (r_state == S_IDLE) ? i_q_data : r_item;
        w_src_run = (r_state == S_IDLE) ? w_run_len : r_run_len;
        w_fresh   = (r_state == S_IDLE) ? !r_bar_open : 1'b1;

        w_base_high    = w_fresh ? w_src.price : r_high;
        w_base_low     = w_fresh ? w_src.price : r_low;
        w_base_vol     = w_fresh ? '0 : r_vol;
        w_base_trades  = w_fresh ? '0 : r_trades;
        w_base_bvol    = w_fresh ? '0 : r_bvol;
        w_base_btrades = w_fresh ? '0 : r_btrades;
        w_base_run     = w_fresh ? '0 : r_max_run;

        w_vol_sum  = {1'b0, w_base_vol} + (VOL_W+1)'(w_src.qty);
        w_bvol_sum = {1'b0, w_base_bvol} + (VOL_W+1)'(w_src.qty);
    end

    always_comb begin
        n_state        = r_state;
        n_bar_open     = r_bar_open;
        n_prev_side    = r_prev_side;
        n_run_count    = r_run_count;
        n_out_valid    = r_out_valid;
        n_bucket_start = r_bucket_start;
        n_open         = r_open;
        n_high         = r_high;
        n_low          = r_low;
        n_close        = r_close;
        n_vol          = r_vol;
        n_trades       = r_trades;
        n_bvol         = r_bvol;
        n_btrades      = r_btrades;
        n_max_run      = r_max_run;
        n_item         = r_item;
        n_run_len      = r_run_len;
        n_gap_time     = r_gap_time;
        n_gap_cnt      = r_gap_cnt;
        n_out          = r_out;
        w_apply        = 1'b0;

        if (w_can_load) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_pop) begin
                    n_prev_side = w_side_next;
                    n_run_count = w_run_next;
                    if (!r_bar_open || !w_new_bucket) begin
                        w_apply = 1'b1;
                    end else begin
                        n_item     = i_q_data;
                        n_run_len  = w_run_len;
                        n_gap_time = {1'b0, r_bucket_start} + (TIME_W+1)'(BUCKET_MS);
                        n_state    = S_BAR;
                    end
                end
            end
            S_BAR: begin
                if (w_can_load) begin
                    n_out_valid           = 1'b1;
                    n_out.bar_time_ms     = r_bucket_start;
                    n_out.open_price      = r_open;
                    n_out.high_price      = r_high;
                    n_out.low_price       = r_low;
                    n_out.close_price     = r_close;
                    n_out.total_volume    = r_vol;
                    n_out.total_trades    = r_trades;
                    n_out.buy_side_volume = r_bvol;
                    n_out.buy_trades      = r_btrades;
                    n_out.longest_run     = r_max_run;
                    n_out.is_gap_bar      = 1'b0;
                    n_out.last            = !w_has_gap;
                    if (w_has_gap) begin
                        n_gap_cnt = '0;
                        n_state   = S_GAP;
                    end else begin
                        w_apply = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_GAP: begin
                if (w_can_load) begin
                    n_out_valid           = 1'b1;
                    n_out.bar_time_ms     = r_gap_time[TIME_W-1:0];
                    n_out.open_price      = r_close;
                    n_out.high_price      = r_close;
                    n_out.low_price       = r_close;
                    n_out.close_price     = r_close;
                    n_out.total_volume    = '0;
                    n_out.total_trades    = '0;
                    n_out.buy_side_volume = '0;
                    n_out.buy_trades      = '0;
                    n_out.longest_run     = '0;
                    n_out.is_gap_bar      = 1'b1;
                    n_out.last            = !w_more_gaps;
                    n_gap_time            = w_gap_next;
                    n_gap_cnt             = w_gap_cnt_inc;
                    if (!w_more_gaps) begin
                        w_apply = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // When a bar closes, the new bar opens in the same cycle as the last result is
        // loaded for output; that result has already taken the old close.
        if (w_apply) begin
            n_bar_open     = 1'b1;
            n_bucket_start = w_src.bucket;
            if (w_fresh) begin
                n_open = w_src.price;
            end
            n_close   = w_src.price;
            n_high    = (w_src.price > w_base_high) ? w_src.price : w_base_high;
            n_low     = (w_src.price < w_base_low) ? w_src.price : w_base_low;
            n_vol     = w_vol_sum[VOL_W] ? '1 : w_vol_sum[VOL_W-1:0];
            n_trades  = (w_base_trades == '1) ? w_base_trades
                                              : w_base_trades + CNT_W'(1);
            n_max_run = (w_src_run > w_base_run) ? w_src_run : w_base_run;
            n_bvol    = w_base_bvol;
            n_btrades = w_base_btrades;
            if (!w_src.sell) begin
                n_bvol    = w_bvol_sum[VOL_W] ? '1 : w_bvol_sum[VOL_W-1:0];
                n_btrades = (w_base_btrades == '1) ? w_base_btrades
                                                   : w_base_btrades + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bar_open  <= 1'b0;
            r_prev_side <= SIDE_NONE;
            r_run_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bar_open  <= n_bar_open;
            r_prev_side <= n_prev_side;
            r_run_count <= n_run_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bucket_start <= n_bucket_start;
        r_open         <= n_open;
        r_high         <= n_high;
        r_low          <= n_low;
        r_close        <= n_close;
        r_vol          <= n_vol;
        r_trades       <= n_trades;
        r_bvol         <= n_bvol;
        r_btrades      <= n_btrades;
        r_max_run      <= n_max_run;
        r_item         <= n_item;
        r_run_len      <= n_run_len;
        r_gap_time     <= n_gap_time;
        r_gap_cnt      <= n_gap_cnt;
        r_out          <= n_out;
    end

endmodule

[src/trade_bar_aggregator_top.sv]
// Throughput: the front end takes a new valid trade only once it has pushed the
// last one; its remainder unit reduces the timestamp one byte per cycle. Invalid
// trades are taken one per cycle while it is idle. A finished bar and its gap bars
// leave at one per cycle while the output is not stalled.
// Reset is synchronous and active low; it clears the control state, empties the
// queue and sets run tracking on. No clearing pass follows reset.
// ----------------------------------------------------------------------------
// trade_bar_aggregator_top
// One-second OHLCV bar builder for a trade stream, with gap-bar filling and
// same-side run tracking.
// ----------------------------------------------------------------------------
module trade_bar_aggregator_top import tba_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  t_trade i_in_data,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    output t_bar   o_out_data,
    input  logic   i_cfg_valid,
    output logic   o_cfg_ready,
    input  logic   i_cfg_data
);

    logic   r_run_track_en;
    logic   w_push;
    logic   w_q_full;
    logic   w_q_valid;
    logic   w_q_pop;
    t_work  w_push_data;
    t_work  w_q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_track_en <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_run_track_en <= i_cfg_data;
        end
    end

    tba_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (w_push),
        .i_full     (w_q_full),
        .o_work     (w_push_data)
    );

    tba_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_data),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_rdata (w_q_data)
    );

    tba_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_run_track_en (r_run_track_en),
        .i_q_valid      (w_q_valid),
        .o_q_pop        (w_q_pop),
        .i_q_data       (w_q_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

    // The front end must never offer a trade to a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_full))
        else $error("trade pushed into a full queue");

    // A gap bar carries no trades and is flat.
    a_gap_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_gap_bar) |->
            (o_out_data.total_trades == '0 && o_out_data.total_volume == '0 &&
             o_out_data.open_price == o_out_data.close_price &&
             o_out_data.high_price == o_out_data.low_price))
        else $error("gap bar is not flat");

    // A finished bar holds at least one trade and a consistent price range.
    a_bar_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.is_gap_bar) |->
            (o_out_data.total_trades != '0 &&
             o_out_data.low_price <= o_out_data.high_price &&
             o_out_data.buy_side_volume <= o_out_data.total_volume))
        else $error("finished bar is inconsistent");

endmodule

[test/trade_bar_aggregator_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trade_bar_aggregator_top_tb
// Drives trades into the bar aggregator and checks every bar it emits against
// an in-bench bar builder. A directed part covers ignored trades, the first
// trade, bucket edges, gap filling up to its cap, time going backward, the
// extreme timestamps and prices, run tracking off and on, and a buy run with
// large volumes. Random trade streams with both sides idling follow.
// ----------------------------------------------------------------------------
module trade_bar_aggregator_top_tb;
    import tba_pkg::*;

    localparam int unsigned HALF_PERIOD_NS = 2;
    localparam int unsigned RESET_CYCLES   = 12;
    localparam int unsigned SETTLE_CYCLES  = 64;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned BURST_LEN      = 6;

    localparam logic [63:0] TIME_MASK = (64'd1 << TIME_W) - 64'd1;
    localparam logic [63:0] VOL_TOP   = (64'd1 << VOL_W) - 64'd1;
    localparam logic [63:0] CNT_TOP   = (64'd1 << CNT_W) - 64'd1;

    localparam logic AGGR_BUY  = 1'b0;
    localparam logic AGGR_SELL = 1'b1;

    typedef enum logic [1:0] {SIDE_NONE, SIDE_BUY, SIDE_SELL} t_side;

    // Builds one-second bars from the accepted trades and holds the bars that
    // the block still owes, oldest first.
    class bar_ledger;
        t_bar               pending_bars[$];
        int unsigned        mismatch_count;
        logic               run_track_en;
        logic               bar_open;
        logic [TIME_W-1:0]  bucket_start;
        logic [PRICE_W-1:0] cur_open, cur_high, cur_low, cur_close;
        logic [VOL_W-1:0]   cur_volume, cur_buy_side_volume;
        logic [CNT_W-1:0]   cur_trades, cur_buy_trades;
        logic [RUN_W-1:0]   cur_max_run, run_count;
        t_side              prev_side;

        function new();
            mismatch_count      = 0;
            run_track_en        = 1'b1;
            bar_open            = 1'b0;
            bucket_start        = '0;
            cur_open            = '0;
            cur_high            = '0;
            cur_low             = '0;
            cur_close           = '0;
            cur_volume          = '0;
            cur_buy_side_volume = '0;
            cur_trades          = '0;
            cur_buy_trades      = '0;
            cur_max_run         = '0;
            run_count           = '0;
            prev_side           = SIDE_NONE;
        endfunction

        function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] top);
            return (a + b > top) ? top : a + b;
        endfunction

        function t_bar make_bar(logic [TIME_W-1:0] at, logic [PRICE_W-1:0] o,
                                logic [PRICE_W-1:0] h, logic [PRICE_W-1:0] l,
                                logic [PRICE_W-1:0] c, logic [VOL_W-1:0] vol,
                                logic [CNT_W-1:0] trd, logic [VOL_W-1:0] bvol,
                                logic [CNT_W-1:0] btrd, logic [RUN_W-1:0] run,
                                logic gap);
            t_bar b;
            b.bar_time_ms     = at;
            b.open_price      = o;
            b.high_price      = h;
            b.low_price       = l;
            b.close_price     = c;
            b.total_volume    = vol;
            b.total_trades    = trd;
            b.buy_side_volume = bvol;
            b.buy_trades      = btrd;
            b.longest_run     = run;
            b.is_gap_bar      = gap;
            b.last            = 1'b0;
            return b;
        endfunction

        // Called for every accepted input transfer.
        function void take_trade(t_trade tr);
            logic [63:0]      bucket;
            logic [63:0]      slot;
            int unsigned      gaps;
            t_side            side;
            logic [RUN_W-1:0] run_len;
            t_bar             held;
            if (tr.trade_time_ms == '0 || tr.trade_price == '0 || tr.trade_qty == '0) begin
                return;
            end
            bucket = (64'(tr.trade_time_ms) / BUCKET_MS) * BUCKET_MS;
            side = tr.seller_aggressor ? SIDE_SELL : SIDE_BUY;
            run_len = 1;
            if (run_track_en) begin
                if (side == prev_side) begin
                    if (run_count != '1) begin
                        run_count++;
                    end
                end else begin
                    prev_side = side;
                    run_count = 1;
                end
                run_len = run_count;
            end
            if (!bar_open || bucket != 64'(bucket_start)) begin
                if (bar_open) begin
                    held = make_bar(bucket_start, cur_open, cur_high, cur_low, cur_close,
                                    cur_volume, cur_trades, cur_buy_side_volume,
                                    cur_buy_trades, cur_max_run, 1'b0);
                    slot = 64'(bucket_start) + BUCKET_MS;
                    gaps = 0;
                    while (slot < bucket && gaps < MAX_GAP_BARS) begin
                        pending_bars = {pending_bars, held};
                        held = make_bar(slot[TIME_W-1:0], cur_close, cur_close, cur_close,
                                        cur_close, '0, '0, '0, '0, '0, 1'b1);
                        gaps++;
                        slot += BUCKET_MS;
                    end
                    // Only the final bar of this trade carries the end marker.
                    held.last = 1'b1;
                    pending_bars = {pending_bars, held};
                end
                bar_open            = 1'b1;
                bucket_start        = bucket[TIME_W-1:0];
                cur_open            = tr.trade_price;
                cur_high            = tr.trade_price;
                cur_low             = tr.trade_price;
                cur_volume          = '0;
                cur_trades          = '0;
                cur_buy_side_volume = '0;
                cur_buy_trades      = '0;
                cur_max_run         = '0;
            end
            cur_close = tr.trade_price;
            if (tr.trade_price > cur_high) begin
                cur_high = tr.trade_price;
            end
            if (tr.trade_price < cur_low) begin
                cur_low = tr.trade_price;
            end
            cur_volume = VOL_W'(sat_add(cur_volume, tr.trade_qty, VOL_TOP));
            cur_trades = CNT_W'(sat_add(cur_trades, 1, CNT_TOP));
            if (run_len > cur_max_run) begin
                cur_max_run = run_len;
            end
            if (side == SIDE_BUY) begin
                cur_buy_side_volume = VOL_W'(sat_add(cur_buy_side_volume, tr.trade_qty,
                                                     VOL_TOP));
                cur_buy_trades = CNT_W'(sat_add(cur_buy_trades, 1, CNT_TOP));
            end
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatch_count++;
                $error("%s: expected %0d, got %0d", field, want, got);
            end
        endfunction

        // Called for every accepted output transfer.
        function void match_bar(t_bar got);
            t_bar want;
            if (pending_bars.size() == 0) begin
                mismatch_count++;
                $error("bar at %0d ms arrived with no trade to account for it",
                       got.bar_time_ms);
                return;
            end
            want = pending_bars.pop_front();
            compare("bar_time_ms", want.bar_time_ms, got.bar_time_ms);
            compare("open_price", want.open_price, got.open_price);
            compare("high_price", want.high_price, got.high_price);
            compare("low_price", want.low_price, got.low_price);
            compare("close_price", want.close_price, got.close_price);
            compare("total_volume", want.total_volume, got.total_volume);
            compare("total_trades", want.total_trades, got.total_trades);
            compare("buy_side_volume", want.buy_side_volume, got.buy_side_volume);
            compare("buy_trades", want.buy_trades, got.buy_trades);
            compare("longest_run", want.longest_run, got.longest_run);
            compare("is_gap_bar", want.is_gap_bar, got.is_gap_bar);
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    t_trade i_in_data   = '0;
    logic   i_out_stall = 1'b0;
    logic   i_cfg_valid = 1'b0;
    logic   i_cfg_data  = 1'b0;
    logic   o_in_stall;
    logic   o_out_valid;
    t_bar   o_out_data;
    logic   o_cfg_ready;

    bar_ledger   ledger = new();
    t_trade      trades_to_send[$];
    logic        sender_idles  = 1'b1;
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    int unsigned quiet_cycles  = 0;
    logic [63:0]        cursor_ms   = '0;
    logic [PRICE_W-1:0] price_level = '0;
    logic               last_sell   = 1'b0;

    trade_bar_aggregator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD_NS i_clk = ~i_clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                ledger.match_bar(o_out_data);
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("trade_bar_aggregator_top_tb failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Result side: random stalls, long free-flowing stretches now and then,
    // and a long hold-off whenever the stimulus asks for one.
    initial begin : receiver
        int unsigned stall_left;
        int unsigned flow_left;
        stall_left = 0;
        flow_left  = 0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                stall_left   = LONG_HOLD;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (flow_left != 0) begin
                    flow_left--;
                end else begin
                    flow_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                             : $urandom_range(1, 8);
                    stall_left = pick_gap();
                end
            end
        end
    end

    function automatic void add_trade(logic [63:0] at, logic [PRICE_W-1:0] price,
                                      logic [QTY_W-1:0] qty, logic sell);
        t_trade tr;
        tr.trade_time_ms    = at[TIME_W-1:0];
        tr.trade_price      = price;
        tr.trade_qty        = qty;
        tr.seller_aggressor = sell;
        trades_to_send = {trades_to_send, tr};
    endfunction

    // Offers the queued trades back to back; valid stays high between
    // transfers unless a gap is drawn.
    task automatic send_queued();
        t_trade      tr;
        int unsigned gap;
        @(posedge i_clk);
        while (trades_to_send.size() != 0) begin
            tr  = trades_to_send.pop_front();
            gap = sender_idles ? pick_gap() : 0;
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= tr;
            do @(posedge i_clk); while (o_in_stall);
            ledger.take_trade(tr);
        end
        i_in_valid <= 1'b0;
    endtask

    // A trade in the same bucket yields no bar, so a quiet margin follows the
    // last bar before the block can be taken as idle.
    task automatic wait_drained();
        while (ledger.pending_bars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_run_track_en(input logic enable);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= enable;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ledger.run_track_en = enable;
    endtask

    // Well-formed streams mostly walk forward through nearby seconds; a few
    // trades step back, leap far ahead, land anywhere or carry a zero field.
    function automatic void queue_random(int unsigned count);
        int unsigned        roll;
        logic [63:0]        wide;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                cursor_ms += $urandom_range(0, 400);
            end else if (roll < 80) begin
                cursor_ms += $urandom_range(600, 3500);
            end else if (roll < 88) begin
                cursor_ms -= $urandom_range(1, 5000);
            end else if (roll < 94) begin
                cursor_ms += $urandom_range(20000, 200000);
            end else begin
                wide      = {$urandom, $urandom};
                cursor_ms = wide;
            end
            cursor_ms &= TIME_MASK;
            if ($urandom_range(0, 7) == 0) begin
                price_level = $urandom;
            end else begin
                price_level = price_level + $urandom_range(0, 20) - 10;
            end
            price = price_level;
            qty = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(1, 500);
            if ($urandom_range(0, 9) < 3) begin
                last_sell = ~last_sell;
            end
            if ($urandom_range(0, 19) == 0) begin
                roll = $urandom_range(0, 2);
                if (roll == 0) begin
                    add_trade('0, price, qty, last_sell);
                end else if (roll == 1) begin
                    add_trade(cursor_ms, '0, qty, last_sell);
                end else begin
                    add_trade(cursor_ms, price, '0, last_sell);
                end
            end else begin
                add_trade(cursor_ms, price, qty, last_sell);
            end
        end
    endfunction

    task automatic run_random(input int unsigned count);
        int unsigned chunk;
        while (count != 0) begin
            chunk = $urandom_range(5, 25);
            if (chunk > count) begin
                chunk = count;
            end
            queue_random(chunk);
            sender_idles = ($urandom_range(0, 3) != 0);
            send_queued();
            count -= chunk;
        end
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_run_track_en(1'b1);

        // Zero time, price and quantity are all dropped before the first bar.
        add_trade(0, 5, 5, AGGR_BUY);
        add_trade(5000, 0, 5, AGGR_BUY);
        add_trade(5000, 5, 0, AGGR_SELL);
        add_trade(5123, '1, '1, AGGR_BUY);
        add_trade(5999, 1, 1, AGGR_BUY);
        add_trade(5500, 1000, 7, AGGR_SELL);
        // A dropped trade in the middle of a run must not break it.
        add_trade(5600, 0, 9, AGGR_SELL);
        add_trade(5700, 900, 3, AGGR_SELL);
        add_trade(6000, 800, 2, AGGR_SELL);
        add_trade(9001, 850, 4, AGGR_BUY);
        add_trade(3000, 10, 10, AGGR_BUY);
        // Exactly as many empty seconds as the cap, then far more than it.
        add_trade(66000, 20, 1, AGGR_BUY);
        add_trade(166999, 30, 1, AGGR_SELL);
        add_trade(TIME_MASK, 40, 2, AGGR_SELL);
        add_trade(TIME_MASK - 5, 41, 3, AGGR_SELL);
        add_trade(1, 42, 1, AGGR_BUY);
        add_trade(999, 43, 1, AGGR_BUY);
        add_trade(1000, 44, 1, AGGR_SELL);
        sender_idles = 1'b1;
        send_queued();

        write_run_track_en(1'b0);
        add_trade(2000, 50, 5, AGGR_SELL);
        add_trade(2100, 51, 5, AGGR_SELL);
        add_trade(2200, 49, 5, AGGR_SELL);
        add_trade(3500, 52, 1, AGGR_SELL);
        send_queued();

        // The run left over from before tracking was switched off resumes here.
        write_run_track_en(1'b1);
        add_trade(3600, 53, 1, AGGR_SELL);
        add_trade(4000, 54, 1, AGGR_SELL);
        // A buy run in one bucket with the largest quantities.
        for (int unsigned n = 0; n < BURST_LEN; n++) begin
            add_trade(20500, $urandom_range(1, 1000), '1, AGGR_BUY);
        end
        add_trade(21000, 70, 1, AGGR_BUY);
        add_trade(22000, 71, 1, AGGR_BUY);
        sender_idles = 1'b0;
        send_queued();

        write_run_track_en(1'b0);
        cursor_ms   = {$urandom, $urandom} & TIME_MASK;
        price_level = $urandom_range(1000, 100000);
        run_random(50);

        write_run_track_en(1'b1);
        // The sender pauses until every bar is out, then keeps offering trades
        // while the result side holds off, so the block fills and stalls.
        wait_drained();
        hold_requests++;
        repeat (30) begin
            cursor_ms = (cursor_ms + 1000 + $urandom_range(0, 1500)) & TIME_MASK;
            add_trade(cursor_ms, $urandom_range(1, 5000), $urandom_range(1, 100),
                      1'($urandom_range(0, 1)));
        end
        sender_idles = 1'b0;
        send_queued();
        run_random(90);

        wait_drained();
        if (ledger.mismatch_count == 0) begin
            $display("trade_bar_aggregator_top_tb passed");
        end else begin
            $display("trade_bar_aggregator_top_tb failed");
        end
        $finish;
    end

endmodule
